>>> hw/rtl/cds_pkg.sv
// Package for the clock divider search block: field types, register indexes,
// register reset values and divider step counts. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cds_pkg;

  typedef logic [9:0]  clk_mhz_t;   // reference clock in MHz
  typedef logic [11:0] freq_t;      // VCO limits, target and output frequency
  typedef logic [15:0] err_t;       // error limit and reported error
  typedef logic [7:0]  div_t;       // multiplier and divider values
  typedef logic [17:0] prod_t;      // reference clock times multiplier
  typedef logic [2:0]  cfg_idx_t;   // configuration register index
  typedef logic [15:0] cfg_data_t;  // configuration write data

  // Configuration register indexes.
  localparam cfg_idx_t CFG_INPUT_CLOCK = 3'd0;
  localparam cfg_idx_t CFG_VCO_MIN     = 3'd1;
  localparam cfg_idx_t CFG_VCO_MAX     = 3'd2;
  localparam cfg_idx_t CFG_ERROR_LIMIT = 3'd3;
  localparam cfg_idx_t CFG_MULT_LOW    = 3'd4;
  localparam cfg_idx_t CFG_MULT_HIGH   = 3'd5;
  localparam cfg_idx_t CFG_INDIV_HIGH  = 3'd6;
  localparam cfg_idx_t CFG_OUTDIV_HIGH = 3'd7;

  // Register values after reset.
  localparam clk_mhz_t RST_INPUT_CLOCK = 10'd100;
  localparam freq_t    RST_VCO_MIN     = 12'd800;
  localparam freq_t    RST_VCO_MAX     = 12'd1600;
  localparam err_t     RST_ERROR_LIMIT = 16'd1000;
  localparam div_t     RST_MULT_LOW    = 8'd2;
  localparam div_t     RST_MULT_HIGH   = 8'd128;
  localparam div_t     RST_INDIV_HIGH  = 8'd106;
  localparam div_t     RST_OUTDIV_HIGH = 8'd128;

  // Steps of the shared divider: the full product, or a 12-bit VCO value.
  localparam logic [4:0] VDIV_STEPS = 5'd18;
  localparam logic [4:0] ODIV_STEPS = 5'd12;

endpackage

`default_nettype wire

>>> hw/rtl/clock_divider_search.sv
// Top level of the clock divider search: sequencer, multiplier and the shared
// bit-serial divider. Depends on cds_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Usage
// A search is started by raising start with the target frequency on
// in_target_mhz; the beat is taken at a rising edge where busy is low. busy
// then stays high until the result has been shown. The result appears on the
// out_ ports for exactly one cycle, marked by out_valid, and the block is idle
// again in the following cycle. The receiver cannot stall the block, so it
// must capture the result in that cycle.
// The eight search limits are written through cfg_we, cfg_addr and cfg_wdata
// while busy is low; they take effect at the next search.
// Timing: one restoring divider producing one quotient bit per cycle does all
// the work. Each multiplier first forms the product; each (multiplier, input
// divider) pair takes a load, 18 division steps, a range check and a step to
// the next pair; each output divider tried takes 12 division steps plus the
// evaluation, which also loads the next divider. The output divider sweep
// stops early once the output frequency has fallen below the target, so with
// a target of zero the sweep runs over every output divider and the search is
// the longest. An exact hit ends the search at once, and an empty multiplier
// or input divider range ends it without trying any candidate.
// Reset: a synchronous low on rst_n returns the sequencer to idle and loads
// the reset values of all configuration registers.
module clock_divider_search #(
  parameter int MULT_LIMIT   = 128,
  parameter int INDIV_LIMIT  = 128,
  parameter int OUTDIV_LIMIT = 128
) (
  input  wire                      clk,
  input  wire                      rst_n,
  // Command channel
  input  wire                      start,
  output logic                     busy,
  input  wire cds_pkg::freq_t      in_target_mhz,
  // Result channel
  output logic                     out_valid,
  output cds_pkg::div_t            out_multiplier,
  output cds_pkg::div_t            out_input_divider,
  output cds_pkg::div_t            out_output_divider,
  output cds_pkg::err_t            out_freq_error,
  output logic                     out_exact_hit,
  output logic                     out_found,
  // Configuration port
  input  wire                      cfg_we,
  input  wire cds_pkg::cfg_idx_t   cfg_addr,
  input  wire cds_pkg::cfg_data_t  cfg_wdata
);
  import cds_pkg::*;

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_VLOAD = 3'd2;
  localparam logic [2:0] S_VDIV  = 3'd3;
  localparam logic [2:0] S_VCHK  = 3'd4;
  localparam logic [2:0] S_ODIV  = 3'd5;
  localparam logic [2:0] S_EVAL  = 3'd6;
  localparam logic [2:0] S_NEXTD = 3'd7;

  // Configuration registers.
  clk_mhz_t input_clock_r;
  freq_t    vco_min_r;
  freq_t    vco_max_r;
  err_t     error_limit_r;
  div_t     mult_low_r;
  div_t     mult_high_r;
  div_t     indiv_high_r;
  div_t     outdiv_high_r;

  // Sequencer and search state.
  logic [2:0] state_r, state_nxt;
  logic       done_r, done_nxt;
  freq_t      target_r, target_nxt;
  div_t       m_r, m_nxt;
  div_t       d_r, d_nxt;
  div_t       o_r, o_nxt;
  prod_t      prod_r, prod_nxt;
  freq_t      vco_r, vco_nxt;
  freq_t      f_r, f_nxt;

  // Best candidate so far.
  err_t       best_err_r, best_err_nxt;
  div_t       bm_r, bm_nxt;
  div_t       bd_r, bd_nxt;
  div_t       bo_r, bo_nxt;
  err_t       berr_r, berr_nxt;
  logic       found_r, found_nxt;
  logic       exact_r, exact_nxt;

  // Shared restoring divider.
  prod_t      quo_r, quo_nxt;
  div_t       rem_r, rem_nxt;
  div_t       dvs_r, dvs_nxt;
  logic [4:0] cnt_r, cnt_nxt;

  // Upper bounds clamped to the build limits.
  div_t       m_hi, d_hi, o_hi;

  // Divider step and candidate evaluation.
  logic [8:0] shl;
  logic       q_bit;
  div_t       rem_step;
  logic       f_ge_t;
  freq_t      err_w;
  logic       vco_in_range;

  always_comb begin
    // A bound is only replaced by a limit below it, so the limit fits 8 bits.
    m_hi = (9'(mult_high_r) > 9'(MULT_LIMIT)) ? 8'(MULT_LIMIT) : mult_high_r;
    d_hi = (9'(indiv_high_r) > 9'(INDIV_LIMIT)) ? 8'(INDIV_LIMIT) : indiv_high_r;
    o_hi = (9'(outdiv_high_r) > 9'(OUTDIV_LIMIT)) ? 8'(OUTDIV_LIMIT) : outdiv_high_r;
  end

  // One quotient bit per cycle: shift the next dividend bit into the
  // remainder and subtract the divisor where it fits.
  always_comb begin
    shl      = {rem_r, quo_r[17]};
    q_bit    = (shl >= {1'b0, dvs_r});
    rem_step = q_bit ? 8'(shl - {1'b0, dvs_r}) : shl[7:0];
  end

  always_comb begin
    f_ge_t       = (f_r >= target_r);
    err_w        = f_ge_t ? (f_r - target_r) : (target_r - f_r);
    vco_in_range = (quo_r >= 18'(vco_min_r)) && (quo_r <= 18'(vco_max_r));
  end

  always_comb begin
    state_nxt    = state_r;
    done_nxt     = 1'b0;
    target_nxt   = target_r;
    m_nxt        = m_r;
    d_nxt        = d_r;
    o_nxt        = o_r;
    prod_nxt     = prod_r;
    vco_nxt      = vco_r;
    f_nxt        = f_r;
    best_err_nxt = best_err_r;
    bm_nxt       = bm_r;
    bd_nxt       = bd_r;
    bo_nxt       = bo_r;
    berr_nxt     = berr_r;
    found_nxt    = found_r;
    exact_nxt    = exact_r;
    quo_nxt      = quo_r;
    rem_nxt      = rem_r;
    dvs_nxt      = dvs_r;
    cnt_nxt      = cnt_r;

    unique case (state_r)
      S_IDLE: begin
        if (start && !done_r) begin
          target_nxt   = in_target_mhz;
          m_nxt        = mult_low_r;
          best_err_nxt = error_limit_r;
          bm_nxt       = '0;
          bd_nxt       = '0;
          bo_nxt       = '0;
          berr_nxt     = '0;
          found_nxt    = 1'b0;
          exact_nxt    = 1'b0;
          // Empty multiplier or input divider range: nothing to try.
          if ((mult_low_r > m_hi) || (d_hi == '0)) begin
            done_nxt = 1'b1;
          end else begin
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        prod_nxt  = 18'(input_clock_r * m_r);
        d_nxt     = 8'd1;
        state_nxt = S_VLOAD;
      end
      S_VLOAD: begin
        quo_nxt   = prod_r;
        rem_nxt   = '0;
        dvs_nxt   = d_r;
        cnt_nxt   = VDIV_STEPS;
        state_nxt = S_VDIV;
      end
      S_VDIV: begin
        quo_nxt = {quo_r[16:0], q_bit};
        rem_nxt = rem_step;
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          state_nxt = S_VCHK;
        end
      end
      S_VCHK: begin
        if (vco_in_range && (o_hi != '0)) begin
          // In range means the VCO fits in 12 bits; start the first output step.
          vco_nxt   = quo_r[11:0];
          o_nxt     = 8'd1;
          quo_nxt   = {quo_r[11:0], 6'd0};
          rem_nxt   = '0;
          dvs_nxt   = 8'd1;
          cnt_nxt   = ODIV_STEPS;
          state_nxt = S_ODIV;
        end else begin
          state_nxt = S_NEXTD;
        end
      end
      S_ODIV: begin
        quo_nxt = {quo_r[16:0], q_bit};
        rem_nxt = rem_step;
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          f_nxt     = {quo_r[10:0], q_bit};
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (err_w == '0) begin
          // Exact hit ends the whole search.
          bm_nxt    = m_r;
          bd_nxt    = d_r;
          bo_nxt    = o_r;
          berr_nxt  = '0;
          found_nxt = 1'b1;
          exact_nxt = 1'b1;
          done_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          if (16'(err_w) < best_err_r) begin
            best_err_nxt = 16'(err_w);
            bm_nxt       = m_r;
            bd_nxt       = d_r;
            bo_nxt       = o_r;
            berr_nxt     = 16'(err_w);
            found_nxt    = 1'b1;
          end
          // The output frequency only falls with larger dividers, so once it
          // is below the target no later divider can do better.
          if (!f_ge_t || (o_r == o_hi)) begin
            state_nxt = S_NEXTD;
          end else begin
            o_nxt     = o_r + 8'd1;
            quo_nxt   = {vco_r, 6'd0};
            rem_nxt   = '0;
            dvs_nxt   = o_r + 8'd1;
            cnt_nxt   = ODIV_STEPS;
            state_nxt = S_ODIV;
          end
        end
      end
      S_NEXTD: begin
        if (d_r != d_hi) begin
          d_nxt     = d_r + 8'd1;
          state_nxt = S_VLOAD;
        end else if (m_r != m_hi) begin
          m_nxt     = m_r + 8'd1;
          state_nxt = S_MUL;
        end else begin
          done_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    target_r   <= target_nxt;
    m_r        <= m_nxt;
    d_r        <= d_nxt;
    o_r        <= o_nxt;
    prod_r     <= prod_nxt;
    vco_r      <= vco_nxt;
    f_r        <= f_nxt;
    best_err_r <= best_err_nxt;
    bm_r       <= bm_nxt;
    bd_r       <= bd_nxt;
    bo_r       <= bo_nxt;
    berr_r     <= berr_nxt;
    found_r    <= found_nxt;
    exact_r    <= exact_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    dvs_r      <= dvs_nxt;
    cnt_r      <= cnt_nxt;
  end

  // Configuration writes, truncated to each register's width.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      input_clock_r <= RST_INPUT_CLOCK;
      vco_min_r     <= RST_VCO_MIN;
      vco_max_r     <= RST_VCO_MAX;
      error_limit_r <= RST_ERROR_LIMIT;
      mult_low_r    <= RST_MULT_LOW;
      mult_high_r   <= RST_MULT_HIGH;
      indiv_high_r  <= RST_INDIV_HIGH;
      outdiv_high_r <= RST_OUTDIV_HIGH;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_INPUT_CLOCK: input_clock_r <= cfg_wdata[9:0];
        CFG_VCO_MIN:     vco_min_r     <= cfg_wdata[11:0];
        CFG_VCO_MAX:     vco_max_r     <= cfg_wdata[11:0];
        CFG_ERROR_LIMIT: error_limit_r <= cfg_wdata;
        CFG_MULT_LOW:    mult_low_r    <= cfg_wdata[7:0];
        CFG_MULT_HIGH:   mult_high_r   <= cfg_wdata[7:0];
        CFG_INDIV_HIGH:  indiv_high_r  <= cfg_wdata[7:0];
        CFG_OUTDIV_HIGH: outdiv_high_r <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // The result cycle still counts as busy; the block is free the cycle after.
  assign busy               = (state_r != S_IDLE) || done_r;
  assign out_valid          = done_r;
  assign out_multiplier     = bm_r;
  assign out_input_divider  = bd_r;
  assign out_output_divider = bo_r;
  assign out_freq_error     = berr_r;
  assign out_exact_hit      = exact_r;
  assign out_found          = found_r;

endmodule

`default_nettype wire

>>> hw/rtl/cds_checker.sv
// Port-level checker for the clock divider search and its bind statement.
// Depends on cds_pkg and on the ports of clock_divider_search.
`timescale 1ns / 1ps
`default_nettype none

module cds_checker (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 start,
  input wire                 busy,
  input wire                 out_valid,
  input wire cds_pkg::div_t  out_multiplier,
  input wire cds_pkg::div_t  out_input_divider,
  input wire cds_pkg::div_t  out_output_divider,
  input wire cds_pkg::err_t  out_freq_error,
  input wire                 out_exact_hit,
  input wire                 out_found
);
  import cds_pkg::*;

  // An accepted command keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after an accepted command");

  // A result is only shown while the block is busy.
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result shown while idle");

  // Each result beat lasts exactly one cycle and frees the block.
  a_valid_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> (!out_valid && !busy))
    else $error("result beat longer than one cycle");

  // An exact hit is a found candidate with zero error.
  a_exact: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_exact_hit) |-> (out_found && (out_freq_error == '0)))
    else $error("exact hit with error or without found");

  // With nothing found all result values are zero.
  a_none: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> ((out_multiplier == '0) && (out_input_divider == '0)
      && (out_output_divider == '0) && (out_freq_error == '0) && !out_exact_hit))
    else $error("non-zero result without a found candidate");

endmodule

bind clock_divider_search cds_checker u_cds_checker (.*);

`default_nettype wire

>>> test/clock_divider_search_tb.sv
// Self-checking testbench for the clock divider search block.
// It predicts every search in software and compares each result beat field by field.
// Depends on cds_pkg and clock_divider_search.
`timescale 1ns / 1ps

module clock_divider_search_tb;
  import cds_pkg::*;

  localparam int MULT_LIMIT   = 128;
  localparam int INDIV_LIMIT  = 128;
  localparam int OUTDIV_LIMIT = 128;

  // The limit leaves ample margin above the slowest correct run.
  localparam int CYCLE_LIMIT  = 5_000_000;

  // The eight search limits as the block holds them.
  typedef struct {
    clk_mhz_t input_clock;
    freq_t    vco_min;
    freq_t    vco_max;
    err_t     error_limit;
    div_t     mult_low;
    div_t     mult_high;
    div_t     indiv_high;
    div_t     outdiv_high;
  } search_cfg_t;

  // One predicted result beat, with the target that caused it for reporting.
  typedef struct {
    freq_t target;
    div_t  multiplier;
    div_t  input_divider;
    div_t  output_divider;
    err_t  freq_error;
    logic  exact_hit;
    logic  found;
  } divider_choice_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  freq_t     in_target_mhz = '0;
  logic      out_valid;
  div_t      out_multiplier;
  div_t      out_input_divider;
  div_t      out_output_divider;
  err_t      out_freq_error;
  logic      out_exact_hit;
  logic      out_found;
  logic      cfg_we = 1'b0;
  cfg_idx_t  cfg_addr = CFG_INPUT_CLOCK;
  cfg_data_t cfg_wdata = '0;

  freq_t           pending_targets[$];
  divider_choice_t expected_choices[$];
  search_cfg_t     cur_cfg;
  divider_choice_t seen_choice;
  int              errors = 0;
  int              cycles = 0;
  int              hold_off = 0;
  bit              steady = 1'b0;

  clock_divider_search #(
    .MULT_LIMIT  (MULT_LIMIT),
    .INDIV_LIMIT (INDIV_LIMIT),
    .OUTDIV_LIMIT(OUTDIV_LIMIT)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_target_mhz     (in_target_mhz),
    .out_valid         (out_valid),
    .out_multiplier    (out_multiplier),
    .out_input_divider (out_input_divider),
    .out_output_divider(out_output_divider),
    .out_freq_error    (out_freq_error),
    .out_exact_hit     (out_exact_hit),
    .out_found         (out_found),
    .cfg_we            (cfg_we),
    .cfg_addr          (cfg_addr),
    .cfg_wdata         (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Exhaustive search over multiplier, input divider and output divider, all
  // ascending. An exact hit stops everything; otherwise only a strictly
  // smaller error, itself strictly below the limit, replaces the best so far.
  function automatic divider_choice_t predict_search(search_cfg_t c, freq_t target);
    divider_choice_t r;
    int unsigned     m_top, d_top, o_top, best, vco, f, err, m, d, o;
    bit              exact;
    r.target = target;
    r.multiplier = '0;
    r.input_divider = '0;
    r.output_divider = '0;
    r.freq_error = '0;
    r.exact_hit = 1'b0;
    r.found = 1'b0;
    m_top = (c.mult_high > MULT_LIMIT) ? MULT_LIMIT : c.mult_high;
    d_top = (c.indiv_high > INDIV_LIMIT) ? INDIV_LIMIT : c.indiv_high;
    o_top = (c.outdiv_high > OUTDIV_LIMIT) ? OUTDIV_LIMIT : c.outdiv_high;
    best = c.error_limit;
    exact = 1'b0;
    for (m = c.mult_low; m <= m_top && !exact; m++) begin
      for (d = 1; d <= d_top && !exact; d++) begin
        vco = (c.input_clock * m) / d;
        if (vco >= c.vco_min && vco <= c.vco_max) begin
          for (o = 1; o <= o_top && !exact; o++) begin
            f = vco / o;
            err = (f > target) ? f - target : target - f;
            if (err == 0 || err < best) begin
              best = err;
              exact = (err == 0);
              r.multiplier = div_t'(m);
              r.input_divider = div_t'(d);
              r.output_divider = div_t'(o);
              r.freq_error = err_t'(err);
              r.exact_hit = exact;
              r.found = 1'b1;
            end
          end
        end
      end
    end
    return r;
  endfunction

  function automatic search_cfg_t make_cfg(int clk_in, int vmin, int vmax, int lim,
                                           int mlo, int mhi, int dhi, int ohi);
    search_cfg_t c;
    c.input_clock = clk_mhz_t'(clk_in);
    c.vco_min = freq_t'(vmin);
    c.vco_max = freq_t'(vmax);
    c.error_limit = err_t'(lim);
    c.mult_low = div_t'(mlo);
    c.mult_high = div_t'(mhi);
    c.indiv_high = div_t'(dhi);
    c.outdiv_high = div_t'(ohi);
    return c;
  endfunction

  // Random limits are narrow: up to 6 multipliers, 6 input and 10 output dividers.
  // The VCO window is mostly placed around a reachable VCO value, so that
  // most searches get past the range check and into the output divider sweep.
  function automatic search_cfg_t random_cfg();
    search_cfg_t c;
    int unsigned m0, d0, v, roll;
    int          lo, hi;
    case ($urandom_range(9))
      0:       c.input_clock = 10'd1023;
      1:       c.input_clock = 10'd1;
      2:       c.input_clock = clk_mhz_t'($urandom_range(0, 1023));
      default: c.input_clock = clk_mhz_t'($urandom_range(1, 1023));
    endcase
    c.mult_low = ($urandom_range(19) == 0) ? div_t'(0) : div_t'($urandom_range(1, 128));
    roll = $urandom_range(19);
    if (roll == 0 && c.mult_low != 0) begin
      c.mult_high = c.mult_low - 1;
    end else if (roll == 1) begin
      c.mult_low = div_t'($urandom_range(124, 128));
      c.mult_high = div_t'($urandom_range(129, 255));
    end else begin
      c.mult_high = c.mult_low + div_t'($urandom_range(0, 5));
    end
    c.indiv_high = ($urandom_range(19) == 0) ? div_t'(0) : div_t'($urandom_range(1, 6));
    c.outdiv_high = ($urandom_range(19) == 0) ? div_t'(0) : div_t'($urandom_range(1, 10));
    m0 = (c.mult_high > c.mult_low) ?
         $urandom_range((c.mult_high > MULT_LIMIT) ? MULT_LIMIT : c.mult_high, c.mult_low) :
         c.mult_low;
    d0 = $urandom_range((c.indiv_high == 0) ? 1 : c.indiv_high, 1);
    v = (c.input_clock * m0) / d0;
    if ($urandom_range(9) == 0) begin
      c.vco_min = freq_t'($urandom);
      c.vco_max = freq_t'($urandom);
    end else begin
      lo = int'(v) - int'($urandom_range(0, 400));
      hi = int'(v) + int'($urandom_range(0, 400));
      c.vco_min = freq_t'((lo < 0) ? 0 : ((lo > 4095) ? 4095 : lo));
      c.vco_max = freq_t'((hi > 4095) ? 4095 : hi);
    end
    case ($urandom_range(2))
      0:       c.error_limit = err_t'($urandom_range(1, 20));
      1:       c.error_limit = 16'hFFFF;
      default: c.error_limit = err_t'($urandom);
    endcase
    return c;
  endfunction

  // Most targets sit on or within a few MHz of a frequency that some triple
  // in range produces; the rest are arbitrary 12-bit values.
  function automatic freq_t pick_target(search_cfg_t c);
    int unsigned m_top, d_top, o_top, f;
    int          t;
    m_top = (c.mult_high > MULT_LIMIT) ? MULT_LIMIT : c.mult_high;
    d_top = (c.indiv_high > INDIV_LIMIT) ? INDIV_LIMIT : c.indiv_high;
    o_top = (c.outdiv_high > OUTDIV_LIMIT) ? OUTDIV_LIMIT : c.outdiv_high;
    if ($urandom_range(99) < 30 || c.mult_low > m_top || d_top == 0 || o_top == 0)
      return freq_t'($urandom);
    f = ((c.input_clock * $urandom_range(m_top, c.mult_low)) / $urandom_range(d_top, 1))
        / $urandom_range(o_top, 1);
    t = int'(f) + int'($urandom_range(6)) - 3;
    return freq_t'((t < 0) ? 0 : ((t > 4095) ? 4095 : t));
  endfunction

  // The bits above a register's width are filled with noise; the block must
  // ignore them.
  task automatic write_reg(cfg_idx_t idx, cfg_data_t value, int width);
    cfg_data_t keep;
    keep = cfg_data_t'((32'h1 << width) - 1);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= (value & keep) | (cfg_data_t'($urandom) & ~keep);
  endtask

  task automatic apply_config(search_cfg_t c);
    cur_cfg = c;
    write_reg(CFG_INPUT_CLOCK, cfg_data_t'(c.input_clock), 10);
    write_reg(CFG_VCO_MIN,     cfg_data_t'(c.vco_min), 12);
    write_reg(CFG_VCO_MAX,     cfg_data_t'(c.vco_max), 12);
    write_reg(CFG_ERROR_LIMIT, cfg_data_t'(c.error_limit), 16);
    write_reg(CFG_MULT_LOW,    cfg_data_t'(c.mult_low), 8);
    write_reg(CFG_MULT_HIGH,   cfg_data_t'(c.mult_high), 8);
    write_reg(CFG_INDIV_HIGH,  cfg_data_t'(c.indiv_high), 8);
    write_reg(CFG_OUTDIV_HIGH, cfg_data_t'(c.outdiv_high), 8);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Every search gives exactly one result, so once the queues are empty and
  // start is low the block is idle; spare cycles follow regardless.
  task automatic wait_drained();
    while (pending_targets.size() != 0 || expected_choices.size() != 0 || start)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Driver. A command beat is taken at an edge where start is high and busy
  // is low; the expectation is computed from the limits in force at that
  // moment. Start is then either kept high with the next target or lowered
  // for a random hold-off, and each free cycle may idle with a small chance.
  // While start is low the target port carries noise, which must be ignored.
  always @(posedge clk) begin : drive_beats
    bit taken;
    taken = start && !busy;
    if (taken) begin
      expected_choices.push_back(predict_search(cur_cfg, in_target_mhz));
      hold_off = (!steady && $urandom_range(99) < 6) ? $urandom_range(1, 40) : 0;
    end
    if (taken || !start) begin
      if (pending_targets.size() != 0 && hold_off == 0 &&
          (steady || $urandom_range(99) >= 6)) begin
        start <= 1'b1;
        in_target_mhz <= pending_targets.pop_front();
      end else begin
        start <= 1'b0;
        in_target_mhz <= freq_t'($urandom);
        if (hold_off > 0) hold_off = hold_off - 1;
      end
    end
  end

  task automatic report_field(string name, int unsigned want_v, int unsigned got_v,
                              freq_t target);
    if (want_v != got_v) begin
      $display("%0t ns: target %0d MHz, %s expected %0d, got %0d",
               $time, target, name, want_v, got_v);
      errors++;
    end
  endtask

  // Monitor. The result beat lasts one cycle and cannot be held off, so it
  // is sampled at every edge while out_valid is high.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_choices.size() == 0) begin
        $display("%0t ns: result beat with no search outstanding, expected none, got m=%0d",
                 $time, out_multiplier);
        errors++;
      end else begin
        seen_choice = expected_choices.pop_front();
        report_field("multiplier", seen_choice.multiplier, out_multiplier,
                     seen_choice.target);
        report_field("input_divider", seen_choice.input_divider, out_input_divider,
                     seen_choice.target);
        report_field("output_divider", seen_choice.output_divider, out_output_divider,
                     seen_choice.target);
        report_field("freq_error", seen_choice.freq_error, out_freq_error,
                     seen_choice.target);
        report_field("exact_hit", seen_choice.exact_hit, out_exact_hit,
                     seen_choice.target);
        report_field("found", seen_choice.found, out_found, seen_choice.target);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL clock_divider_search");
      $finish;
    end
  end

  initial begin : stimulus
    int p, k;
    cur_cfg = make_cfg(RST_INPUT_CLOCK, RST_VCO_MIN, RST_VCO_MAX, RST_ERROR_LIMIT,
                       RST_MULT_LOW, RST_MULT_HIGH, RST_INDIV_HIGH, RST_OUTDIV_HIGH);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset limits: the first VCO in range gives 800 MHz straight away, so
    // both of these end early on an exact hit.
    pending_targets.push_back(12'd800);
    pending_targets.push_back(12'd400);
    wait_drained();

    // Narrow ranges: two exact hits, nearest matches at the bottom of the target
    // field, and its top end, which no triple comes close enough to.
    apply_config(make_cfg(100, 800, 1600, 1000, 8, 12, 4, 8));
    pending_targets.push_back(12'd0);
    pending_targets.push_back(12'd4095);
    pending_targets.push_back(12'd1000);
    pending_targets.push_back(12'd333);
    pending_targets.push_back(12'd1);
    wait_drained();

    // An error limit of zero still accepts an exact hit, and nothing else.
    apply_config(make_cfg(100, 800, 1600, 0, 8, 12, 4, 8));
    pending_targets.push_back(12'd1000);
    pending_targets.push_back(12'd999);
    wait_drained();

    // Fastest reference clock, widest VCO window including zero, largest
    // error limit, and a multiplier of zero giving a VCO of zero.
    apply_config(make_cfg(1023, 0, 4095, 65535, 0, 3, 3, 4));
    pending_targets.push_back(12'd0);
    pending_targets.push_back(12'd4095);
    pending_targets.push_back(12'd2046);
    pending_targets.push_back(12'd1);
    wait_drained();

    // Upper bounds beyond the parameters must be clamped. A target of zero
    // sweeps every output divider, so an unclamped one would go further.
    apply_config(make_cfg(100, 1200, 1300, 65535, 126, 255, 255, 255));
    pending_targets.push_back(12'd640);
    pending_targets.push_back(12'd0);
    pending_targets.push_back(12'd4095);
    pending_targets.push_back(12'd1);
    wait_drained();

    // Here only input dividers above the clamp would land in the VCO window,
    // so a correct block finds nothing.
    apply_config(make_cfg(1023, 990, 1000, 65535, 126, 255, 255, 128));
    pending_targets.push_back(12'd7);
    wait_drained();

    // Empty ranges: lowest multiplier above the clamped highest, lowest above
    // highest, and each divider bound at zero.
    apply_config(make_cfg(100, 800, 1600, 1000, 200, 255, 106, 128));
    pending_targets.push_back(12'd800);
    wait_drained();
    apply_config(make_cfg(100, 800, 1600, 1000, 60, 59, 106, 128));
    pending_targets.push_back(12'd800);
    wait_drained();
    apply_config(make_cfg(100, 800, 1600, 1000, 8, 12, 0, 8));
    pending_targets.push_back(12'd800);
    wait_drained();
    apply_config(make_cfg(100, 800, 1600, 1000, 8, 12, 4, 0));
    pending_targets.push_back(12'd800);
    wait_drained();

    // Random part: eight settings of the limits with ten searches each. The
    // middle settings run with no idling at all on the command side.
    for (p = 0; p < 8; p++) begin
      steady = (p >= 3 && p <= 5);
      apply_config(random_cfg());
      for (k = 0; k < 10; k++)
        pending_targets.push_back(pick_target(cur_cfg));
      wait_drained();
    end

    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("PASS clock_divider_search");
    end else begin
      $display("FAIL clock_divider_search");
    end
    $finish;
  end

endmodule
